[sv/wcc_pkg.sv]
`timescale 1ns / 1ps

package wcc_pkg;

  // Number format and internal precision of the unit vector.
  localparam int DATA_WIDTH = 24;
  localparam int FRAC_BITS  = 16;
  localparam int UNIT_BITS  = 28;

  // Tolerances scaled to the fixed-point format.
  localparam longint ONE_Q          = 64'sd1 <<< FRAC_BITS;
  localparam longint TOL_STILL_RAW  = (ONE_Q + 500000) / 1000000;
  localparam longint TOL_STILL      = (TOL_STILL_RAW > 0) ? TOL_STILL_RAW : 1;
  localparam longint TOL_HOVER_RAW  = (ONE_Q + 500) / 1000;
  localparam longint TOL_HOVER      = (TOL_HOVER_RAW > 0) ? TOL_HOVER_RAW : 1;
  localparam longint TOL_SQ         = ((64'sd1 <<< (2 * FRAC_BITS)) + 500) / 1000;

  // Internal widths, derived from the data width and the unit precision.
  localparam int SQ_W    = 2 * DATA_WIDTH - 1;         // square of a magnitude
  localparam int RAD_W   = 2 * DATA_WIDTH;             // sum of two squares
  localparam int LEN_W   = RAD_W / 2;                  // vector length
  localparam int QUO_W   = UNIT_BITS + 1;              // unit component magnitude
  localparam int NUM_W   = DATA_WIDTH + UNIT_BITS + 1; // divider numerator
  localparam int UNIT_W  = QUO_W + 1;                  // signed unit component
  localparam int PROD_W  = DATA_WIDTH + UNIT_W;        // data times unit
  localparam int PROJ_W  = DATA_WIDTH + 2;             // projection and orthogonal part
  localparam int PPROD_W = PROJ_W + UNIT_W;            // projection times unit
  localparam int OSQ_W   = 2 * PROJ_W - 1;             // square of orthogonal component
  localparam int FO2_W   = OSQ_W + 1;                  // squared orthogonal length
  localparam int K2_W    = FO2_W + 1;                  // airspeed square minus that
  localparam int VP_W    = PROJ_W + 1;                 // ground speed along the unit
  localparam int DIFF_W  = VP_W + 1;                   // speed error
  localparam int CAND_W  = PROJ_W + 2;                 // course before saturation

  localparam logic signed [CAND_W-1:0] SAT_HI =
    CAND_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
  localparam logic signed [CAND_W-1:0] SAT_LO =
    CAND_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] want_north;
    logic signed [DATA_WIDTH-1:0] want_east;
    logic signed [DATA_WIDTH-1:0] drift_north;
    logic signed [DATA_WIDTH-1:0] drift_east;
    logic signed [DATA_WIDTH-1:0] airspeed;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] course_north;
    logic signed [DATA_WIDTH-1:0] course_east;
    logic                         reachable;
  } rsp_t;

  // Everything an item carries down the pipeline; each stage fills its part.
  typedef struct packed {
    req_t                      req;
    logic [SQ_W-1:0]           sq_vn;
    logic [SQ_W-1:0]           sq_ve;
    logic [SQ_W-1:0]           sq_fn;
    logic [SQ_W-1:0]           sq_fe;
    logic [SQ_W-1:0]           s2;
    logic [RAD_W-1:0]          sum_v;
    logic [RAD_W-1:0]          sum_f;
    logic [LEN_W-1:0]          v;
    logic                      still;
    logic                      reach_still;
    logic signed [UNIT_W-1:0]  un;
    logic signed [UNIT_W-1:0]  ue;
    logic signed [PROD_W-1:0]  pn;
    logic signed [PROD_W-1:0]  pe;
    logic signed [PROJ_W-1:0]  fp;
    logic signed [PPROD_W-1:0] qn;
    logic signed [PPROD_W-1:0] qe;
    logic signed [PROJ_W-1:0]  fon;
    logic signed [PROJ_W-1:0]  foe;
    logic [OSQ_W-1:0]          sqn;
    logic [OSQ_W-1:0]          sqe;
    logic [FO2_W-1:0]          fo2;
    logic signed [K2_W-1:0]    k2;
    logic                      no_int;
    logic                      tangent;
    logic signed [PROD_W-1:0]  kn;
    logic signed [PROD_W-1:0]  ke;
    logic signed [VP_W-1:0]    vp1;
    logic signed [VP_W-1:0]    vp2;
    logic signed [PROJ_W-1:0]  kun;
    logic signed [PROJ_W-1:0]  kue;
    logic [DIFF_W-1:0]         d1;
    logic [DIFF_W-1:0]         d2;
    logic signed [CAND_W-1:0]  cn;
    logic signed [CAND_W-1:0]  ce;
    logic                      reach_root;
  } ctx_t;

  // Magnitude of a data word; the most negative value maps to 2^(DATA_WIDTH-1).
  function automatic logic [DATA_WIDTH-1:0] mag_data(input logic signed [DATA_WIDTH-1:0] x);
    return x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);
  endfunction

  // Clamp a course component to the signed data range.
  function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [CAND_W-1:0] x);
    logic signed [CAND_W-1:0] c;
    c = x;
    if (x > SAT_HI) c = SAT_HI;
    if (x < SAT_LO) c = SAT_LO;
    return c[DATA_WIDTH-1:0];
  endfunction

endpackage

[sv/wcc_isqrt.sv]
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage, several lanes
// sharing one valid bit and one sideband word.
module wcc_isqrt #(
  parameter int RAD_W = 48,
  parameter int LANES = 1,
  parameter int PAY_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [LANES-1:0][RAD_W-1:0]      rad,
  input  logic [PAY_W-1:0]                 in_pay,
  output logic                             out_valid,
  output logic [LANES-1:0][RAD_W/2-1:0]    root,
  output logic [PAY_W-1:0]                 out_pay
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int STAGES = ROOT_W;

  logic [RAD_W-1:0] rem_q [STAGES][LANES];
  logic [RAD_W-1:0] rem_next [STAGES][LANES];
  logic [RAD_W-1:0] acc_q [STAGES][LANES];
  logic [RAD_W-1:0] acc_next [STAGES][LANES];
  logic [PAY_W-1:0] pay_q [STAGES];
  logic [PAY_W-1:0] pay_next [STAGES];
  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_next;

  // Each stage tries one power of four against the running remainder.
  always_comb begin
    logic [RAD_W-1:0] rem_in;
    logic [RAD_W-1:0] acc_in;
    logic [RAD_W-1:0] bitv;
    logic [RAD_W:0]   trial;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        vld_next[i] = in_valid;
        pay_next[i] = in_pay;
      end else begin
        vld_next[i] = vld_q[i-1];
        pay_next[i] = pay_q[i-1];
      end
      bitv = RAD_W'(1) << (2 * (STAGES - 1 - i));
      for (int l = 0; l < LANES; l++) begin
        if (i == 0) begin
          rem_in = rad[l];
          acc_in = '0;
        end else begin
          rem_in = rem_q[i-1][l];
          acc_in = acc_q[i-1][l];
        end
        trial = {1'b0, acc_in} + {1'b0, bitv};
        if ({1'b0, rem_in} >= trial) begin
          rem_next[i][l] = rem_in - trial[RAD_W-1:0];
          acc_next[i][l] = (acc_in >> 1) + bitv;
        end else begin
          rem_next[i][l] = rem_in;
          acc_next[i][l] = acc_in >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    rem_q <= rem_next;
    acc_q <= acc_next;
    pay_q <= pay_next;
  end

  // The last stage holds the finished roots.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root[l] = acc_q[STAGES-1][l][ROOT_W-1:0];
    end
  end

  assign out_valid = vld_q[STAGES-1];
  assign out_pay   = pay_q[STAGES-1];

endmodule

[sv/wcc_udiv.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, several
// numerators over one shared divisor.
module wcc_udiv #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 24,
  parameter int QUO_W = 29,
  parameter int LANES = 1,
  parameter int PAY_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]            den,
  input  logic [PAY_W-1:0]            in_pay,
  output logic                        out_valid,
  output logic [LANES-1:0][QUO_W-1:0] quo,
  output logic [PAY_W-1:0]            out_pay
);

  localparam int CW     = DEN_W + QUO_W;
  localparam int STAGES = QUO_W;

  logic [CW-1:0]    rem_q [STAGES][LANES];
  logic [CW-1:0]    rem_next [STAGES][LANES];
  logic [QUO_W-1:0] quo_q [STAGES][LANES];
  logic [QUO_W-1:0] quo_next [STAGES][LANES];
  logic [DEN_W-1:0] den_q [STAGES];
  logic [DEN_W-1:0] den_next [STAGES];
  logic [PAY_W-1:0] pay_q [STAGES];
  logic [PAY_W-1:0] pay_next [STAGES];
  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_next;

  // Stage i decides quotient bit QUO_W-1-i against the shifted divisor.
  always_comb begin
    logic [CW-1:0]    rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [CW-1:0]    shifted;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        vld_next[i] = in_valid;
        pay_next[i] = in_pay;
        den_next[i] = den;
      end else begin
        vld_next[i] = vld_q[i-1];
        pay_next[i] = pay_q[i-1];
        den_next[i] = den_q[i-1];
      end
      shifted = CW'(den_next[i]) << (STAGES - 1 - i);
      for (int l = 0; l < LANES; l++) begin
        if (i == 0) begin
          rem_in = CW'(num[l]);
          quo_in = '0;
        end else begin
          rem_in = rem_q[i-1][l];
          quo_in = quo_q[i-1][l];
        end
        if (rem_in >= shifted) begin
          rem_next[i][l] = rem_in - shifted;
          quo_next[i][l] = quo_in | (QUO_W'(1) << (STAGES - 1 - i));
        end else begin
          rem_next[i][l] = rem_in;
          quo_next[i][l] = quo_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    rem_q <= rem_next;
    quo_q <= quo_next;
    den_q <= den_next;
    pay_q <= pay_next;
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = quo_q[STAGES-1][l];
    end
  end

  assign out_valid = vld_q[STAGES-1];
  assign out_pay   = pay_q[STAGES-1];

endmodule

[sv/wind_course_correction.sv]
// Wind-triangle course solver. A beat is taken on every clock edge where start
// is high; busy never rises, so a new set of vectors can enter every cycle.
// Each beat yields exactly one result, marked by done for one cycle. The path
// runs through the two 24-stage square-root pipelines (vector lengths, then the
// along-track speed) and the 29-stage divider that forms the unit vector; the
// remaining stages hold the multiplications, sums and the final case selection
// with saturation.
// The receiver must take each result in the cycle it appears.
`timescale 1ns / 1ps

module wind_course_correction (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  wcc_pkg::req_t req,
  output logic          done,
  output wcc_pkg::rsp_t rsp
);

  localparam int DATA_WIDTH = wcc_pkg::DATA_WIDTH;
  localparam int UNIT_BITS  = wcc_pkg::UNIT_BITS;
  localparam int SQ_W       = wcc_pkg::SQ_W;
  localparam int RAD_W      = wcc_pkg::RAD_W;
  localparam int LEN_W      = wcc_pkg::LEN_W;
  localparam int QUO_W      = wcc_pkg::QUO_W;
  localparam int NUM_W      = wcc_pkg::NUM_W;
  localparam int UNIT_W     = wcc_pkg::UNIT_W;
  localparam int PROD_W     = wcc_pkg::PROD_W;
  localparam int PROJ_W     = wcc_pkg::PROJ_W;
  localparam int PPROD_W    = wcc_pkg::PPROD_W;
  localparam int OSQ_W      = wcc_pkg::OSQ_W;
  localparam int FO2_W      = wcc_pkg::FO2_W;
  localparam int K2_W       = wcc_pkg::K2_W;
  localparam int VP_W       = wcc_pkg::VP_W;
  localparam int DIFF_W     = wcc_pkg::DIFF_W;
  localparam int CAND_W     = wcc_pkg::CAND_W;
  localparam int CTX_W      = $bits(wcc_pkg::ctx_t);

  localparam logic [LEN_W-1:0]           TOL_STILL_L = LEN_W'(wcc_pkg::TOL_STILL);
  localparam logic [LEN_W:0]             TOL_HOVER_L = (LEN_W + 1)'(wcc_pkg::TOL_HOVER);
  localparam logic signed [K2_W-1:0]     TOL_SQ_POS  = K2_W'(wcc_pkg::TOL_SQ);
  localparam logic signed [K2_W-1:0]     TOL_SQ_NEG  = K2_W'(-wcc_pkg::TOL_SQ);
  localparam logic signed [PROD_W-1:0]   HALF_P      = PROD_W'(64'sd1 <<< (UNIT_BITS - 1));
  localparam logic signed [PPROD_W-1:0]  HALF_Q      = PPROD_W'(64'sd1 <<< (UNIT_BITS - 1));

  wcc_pkg::ctx_t st1, st2, st3, st4, st5, st6, st7, st8, st9, st10, st11, st12;
  wcc_pkg::ctx_t st13, st14, st15;
  wcc_pkg::ctx_t st1_next, st2_next, st3_next, st4_next, st5_next, st6_next;
  wcc_pkg::ctx_t st7_next, st8_next, st9_next, st10_next, st11_next, st12_next;
  wcc_pkg::ctx_t st13_next, st14_next, st15_next;
  logic st1_vld, st2_vld, st3_vld, st4_vld, st5_vld, st6_vld, st7_vld, st8_vld;
  logic st9_vld, st10_vld, st11_vld, st12_vld, st13_vld, st14_vld, st15_vld;

  logic                     in_acc;
  logic [DATA_WIDTH-1:0]    m_vn, m_ve, m_fn, m_fe, m_s;
  logic [1:0][RAD_W-1:0]    sq1_rad;
  logic [1:0][LEN_W-1:0]    sq1_root;
  logic                     sq1_vld;
  wcc_pkg::ctx_t            sq1_ctx;
  logic [DATA_WIDTH-1:0]    m_s4;
  logic signed [LEN_W:0]    hov;
  logic [LEN_W:0]           hov_abs;
  logic [1:0][NUM_W-1:0]    dv_num;
  logic [1:0][QUO_W-1:0]    dv_quo;
  logic                     dv_vld;
  wcc_pkg::ctx_t            dv_ctx;
  logic signed [UNIT_W-1:0] uq_n, uq_e;
  logic signed [PPROD_W-1:0] rq_n, rq_e;
  logic [PROJ_W-1:0]        fo_mn, fo_me;
  wcc_pkg::ctx_t            k_ctx;
  logic [0:0][RAD_W-1:0]    k_rad;
  logic [0:0][LEN_W-1:0]    k_root;
  logic                     k_vld;
  wcc_pkg::ctx_t            k_out;
  logic signed [LEN_W:0]    kk;
  logic signed [DIFF_W-1:0] e1, e2;
  logic                     pick1;
  wcc_pkg::rsp_t            rsp_next;

  // The pipeline never stalls, so a beat is taken whenever start is high.
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  // Valid bits of the hand-built stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_vld  <= 1'b0;
      st2_vld  <= 1'b0;
      st3_vld  <= 1'b0;
      st4_vld  <= 1'b0;
      st5_vld  <= 1'b0;
      st6_vld  <= 1'b0;
      st7_vld  <= 1'b0;
      st8_vld  <= 1'b0;
      st9_vld  <= 1'b0;
      st10_vld <= 1'b0;
      st11_vld <= 1'b0;
      st12_vld <= 1'b0;
      st13_vld <= 1'b0;
      st14_vld <= 1'b0;
      st15_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      st1_vld  <= in_acc;
      st2_vld  <= st1_vld;
      st3_vld  <= st2_vld;
      st4_vld  <= sq1_vld;
      st5_vld  <= dv_vld;
      st6_vld  <= st5_vld;
      st7_vld  <= st6_vld;
      st8_vld  <= st7_vld;
      st9_vld  <= st8_vld;
      st10_vld <= st9_vld;
      st11_vld <= st10_vld;
      st12_vld <= st11_vld;
      st13_vld <= k_vld;
      st14_vld <= st13_vld;
      st15_vld <= st14_vld;
      done     <= st15_vld;
    end
  end

  // Magnitudes for the length squares.
  always_comb begin
    m_vn = wcc_pkg::mag_data(st1.req.want_north);
    m_ve = wcc_pkg::mag_data(st1.req.want_east);
    m_fn = wcc_pkg::mag_data(st1.req.drift_north);
    m_fe = wcc_pkg::mag_data(st1.req.drift_east);
    m_s  = wcc_pkg::mag_data(st1.req.airspeed);
  end

  // Input register, squares, then the sums of squares.
  always_comb begin
    st1_next     = '0;
    st1_next.req = req;

    st2_next       = st1;
    st2_next.sq_vn = SQ_W'(RAD_W'(m_vn) * RAD_W'(m_vn));
    st2_next.sq_ve = SQ_W'(RAD_W'(m_ve) * RAD_W'(m_ve));
    st2_next.sq_fn = SQ_W'(RAD_W'(m_fn) * RAD_W'(m_fn));
    st2_next.sq_fe = SQ_W'(RAD_W'(m_fe) * RAD_W'(m_fe));
    st2_next.s2    = SQ_W'(RAD_W'(m_s) * RAD_W'(m_s));

    st3_next       = st2;
    st3_next.sum_v = RAD_W'(st2.sq_vn) + RAD_W'(st2.sq_ve);
    st3_next.sum_f = RAD_W'(st2.sq_fn) + RAD_W'(st2.sq_fe);
  end

  // Lengths of the desired velocity (lane 0) and the wind (lane 1).
  assign sq1_rad[0] = st3.sum_v;
  assign sq1_rad[1] = st3.sum_f;

  wcc_isqrt #(
    .RAD_W (RAD_W),
    .LANES (2),
    .PAY_W (CTX_W)
  ) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st3_vld),
    .rad       (sq1_rad),
    .in_pay    (st3),
    .out_valid (sq1_vld),
    .root      (sq1_root),
    .out_pay   (sq1_ctx)
  );

  // Standing-still check and its hover test against the airspeed.
  always_comb begin
    m_s4    = wcc_pkg::mag_data(sq1_ctx.req.airspeed);
    hov     = $signed({1'b0, sq1_root[1]}) - $signed({1'b0, m_s4});
    hov_abs = hov[LEN_W] ? (LEN_W + 1)'(-hov) : (LEN_W + 1)'(hov);
  end

  always_comb begin
    st4_next             = sq1_ctx;
    st4_next.v           = sq1_root[0];
    st4_next.still       = sq1_root[0] < TOL_STILL_L;
    st4_next.reach_still = hov_abs < TOL_HOVER_L;
  end

  // Unit vector magnitudes, rounded to nearest.
  assign dv_num[0] = (NUM_W'(wcc_pkg::mag_data(st4.req.want_north)) << UNIT_BITS)
                     + NUM_W'(st4.v >> 1);
  assign dv_num[1] = (NUM_W'(wcc_pkg::mag_data(st4.req.want_east)) << UNIT_BITS)
                     + NUM_W'(st4.v >> 1);

  wcc_udiv #(
    .NUM_W (NUM_W),
    .DEN_W (LEN_W),
    .QUO_W (QUO_W),
    .LANES (2),
    .PAY_W (CTX_W)
  ) u_unit_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st4_vld),
    .num       (dv_num),
    .den       (st4.v),
    .in_pay    (st4),
    .out_valid (dv_vld),
    .quo       (dv_quo),
    .out_pay   (dv_ctx)
  );

  // Rounding and sign fixes between the multiplier stages.
  always_comb begin
    uq_n  = $signed({1'b0, dv_quo[0]});
    uq_e  = $signed({1'b0, dv_quo[1]});
    rq_n  = (st8.qn + HALF_Q) >>> UNIT_BITS;
    rq_e  = (st8.qe + HALF_Q) >>> UNIT_BITS;
    fo_mn = st9.fon[PROJ_W-1] ? PROJ_W'(-st9.fon) : PROJ_W'(st9.fon);
    fo_me = st9.foe[PROJ_W-1] ? PROJ_W'(-st9.foe) : PROJ_W'(st9.foe);
  end

  // Signed unit vector, wind projection, the orthogonal wind part and its squared length against the airspeed square.
  always_comb begin
    st5_next    = dv_ctx;
    st5_next.un = dv_ctx.req.want_north[DATA_WIDTH-1] ? -uq_n : uq_n;
    st5_next.ue = dv_ctx.req.want_east[DATA_WIDTH-1] ? -uq_e : uq_e;

    st6_next    = st5;
    st6_next.pn = PROD_W'($signed(st5.req.drift_north)) * PROD_W'(st5.un);
    st6_next.pe = PROD_W'($signed(st5.req.drift_east)) * PROD_W'(st5.ue);

    st7_next    = st6;
    st7_next.fp = PROJ_W'((st6.pn + st6.pe + HALF_P) >>> UNIT_BITS);

    st8_next    = st7;
    st8_next.qn = PPROD_W'(st7.fp) * PPROD_W'(st7.un);
    st8_next.qe = PPROD_W'(st7.fp) * PPROD_W'(st7.ue);

    st9_next     = st8;
    st9_next.fon = PROJ_W'(PPROD_W'($signed(st8.req.drift_north)) - rq_n);
    st9_next.foe = PROJ_W'(PPROD_W'($signed(st8.req.drift_east)) - rq_e);

    st10_next     = st9;
    st10_next.sqn = OSQ_W'((2 * PROJ_W)'(fo_mn) * (2 * PROJ_W)'(fo_mn));
    st10_next.sqe = OSQ_W'((2 * PROJ_W)'(fo_me) * (2 * PROJ_W)'(fo_me));

    st11_next     = st10;
    st11_next.fo2 = FO2_W'(st10.sqn) + FO2_W'(st10.sqe);

    st12_next    = st11;
    st12_next.k2 = $signed(K2_W'(st11.s2)) - $signed(K2_W'(st11.fo2));
  end

  // Classify the circle-line intersection before the second root.
  always_comb begin
    k_ctx         = st12;
    k_ctx.no_int  = st12.k2 <= TOL_SQ_NEG;
    k_ctx.tangent = st12.k2 <= TOL_SQ_POS;
    k_rad[0]      = k_ctx.tangent ? '0 : RAD_W'(st12.k2);
  end

  wcc_isqrt #(
    .RAD_W (RAD_W),
    .LANES (1),
    .PAY_W (CTX_W)
  ) u_root_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st12_vld),
    .rad       (k_rad),
    .in_pay    (k_ctx),
    .out_valid (k_vld),
    .root      (k_root),
    .out_pay   (k_out)
  );

  // Speed errors of the two roots and the root choice.
  always_comb begin
    kk    = $signed({1'b0, k_root[0]});
    e1    = $signed(DIFF_W'(st13.v)) - DIFF_W'(st13.vp1);
    e2    = $signed(DIFF_W'(st13.v)) - DIFF_W'(st13.vp2);
    pick1 = ~st14.vp1[VP_W-1] && (st14.d1 < st14.d2);
  end

  always_comb begin
    st13_next     = k_out;
    st13_next.kn  = PROD_W'(kk) * PROD_W'(k_out.un);
    st13_next.ke  = PROD_W'(kk) * PROD_W'(k_out.ue);
    st13_next.vp1 = VP_W'(k_out.fp) - VP_W'(kk);
    st13_next.vp2 = VP_W'(k_out.fp) + VP_W'(kk);

    st14_next     = st13;
    st14_next.kun = PROJ_W'((st13.kn + HALF_P) >>> UNIT_BITS);
    st14_next.kue = PROJ_W'((st13.ke + HALF_P) >>> UNIT_BITS);
    st14_next.d1  = e1[DIFF_W-1] ? DIFF_W'(-e1) : DIFF_W'(e1);
    st14_next.d2  = e2[DIFF_W-1] ? DIFF_W'(-e2) : DIFF_W'(e2);

    st15_next            = st14;
    st15_next.cn         = pick1 ? (-CAND_W'(st14.kun) - CAND_W'(st14.fon))
                                 : (CAND_W'(st14.kun) - CAND_W'(st14.fon));
    st15_next.ce         = pick1 ? (-CAND_W'(st14.kue) - CAND_W'(st14.foe))
                                 : (CAND_W'(st14.kue) - CAND_W'(st14.foe));
    st15_next.reach_root = pick1 | ~st14.vp2[VP_W-1];
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    st1  <= st1_next;
    st2  <= st2_next;
    st3  <= st3_next;
    st4  <= st4_next;
    st5  <= st5_next;
    st6  <= st6_next;
    st7  <= st7_next;
    st8  <= st8_next;
    st9  <= st9_next;
    st10 <= st10_next;
    st11 <= st11_next;
    st12 <= st12_next;
    st13 <= st13_next;
    st14 <= st14_next;
    st15 <= st15_next;
  end

  // Final case selection with saturation.
  always_comb begin
    if (st15.still) begin
      rsp_next.course_north = wcc_pkg::sat_data(-CAND_W'(st15.req.drift_north));
      rsp_next.course_east  = wcc_pkg::sat_data(-CAND_W'(st15.req.drift_east));
      rsp_next.reachable    = st15.reach_still;
    end else if (st15.no_int) begin
      rsp_next.course_north = st15.req.want_north;
      rsp_next.course_east  = st15.req.want_east;
      rsp_next.reachable    = 1'b0;
    end else if (st15.tangent) begin
      rsp_next.course_north = wcc_pkg::sat_data(-CAND_W'(st15.fon));
      rsp_next.course_east  = wcc_pkg::sat_data(-CAND_W'(st15.foe));
      rsp_next.reachable    = 1'b1;
    end else begin
      rsp_next.course_north = wcc_pkg::sat_data(st15.cn);
      rsp_next.course_east  = wcc_pkg::sat_data(st15.ce);
      rsp_next.reachable    = st15.reach_root;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule
